FILE: sv/connection_limit_table_defines.svh
// ----------------------------------------------------------------------------
// Connection limit table assertion macros
// Concurrent check macros shared by the connection limit table RTL.
// ----------------------------------------------------------------------------
`ifndef CONNECTION_LIMIT_TABLE_DEFINES_SVH
`define CONNECTION_LIMIT_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CLT_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CLT_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CLT_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define CLT_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: sv/clt_pkg.sv
// ----------------------------------------------------------------------------
// Connection limit table package
// Shared constants, codes, types and the key byte mask function.
// ----------------------------------------------------------------------------
package clt_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int KEY_BYTES_DEF     = 16;
	localparam int KEY_MAX_BYTES     = 16;

	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [1:0] REG_CONN_LIMIT    = 2'd0;
	localparam logic [1:0] REG_DRY_RUN       = 2'd1;
	localparam logic [1:0] REG_REJECT_STATUS = 2'd2;

	localparam logic [15:0] CONN_LIMIT_RST    = 16'd1;
	localparam logic [9:0]  REJECT_STATUS_RST = 10'd503;

	typedef enum logic [2:0] {
		ST_PASSED          = 3'd0,
		ST_REJECTED        = 3'd1,
		ST_REJECTED_DRY    = 3'd2,
		ST_SKIPPED         = 3'd3,
		ST_RELEASED        = 3'd4,
		ST_RELEASE_UNKNOWN = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_UPDATE,
		S_RESP
	} state_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic scan;
		logic update;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic sweep_last;
		logic done;
	} sts_t;

	// keeps key bytes below len
	function automatic logic [8*KEY_MAX_BYTES-1:0] byte_mask(input logic [4:0] len);
		logic [8*KEY_MAX_BYTES-1:0] m;
		m = '0;
		for (int b = 0; b < KEY_MAX_BYTES; b++) begin
			m[8*b +: 8] = {8{5'(b) < len}};
		end
		return m;
	endfunction

endpackage

FILE: sv/clt_datapath.sv
// ----------------------------------------------------------------------------
// Connection limit table datapath
// Entry memory, scan compare, update decision and result registers.
// ----------------------------------------------------------------------------
module clt_datapath #(
	parameter int TABLE_ENTRIES = clt_pkg::TABLE_ENTRIES_DEF,
	parameter int KEY_BYTES     = clt_pkg::KEY_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  clt_pkg::cmd_t       cmd,
	output clt_pkg::sts_t       sts,
	input  logic                operation,
	input  logic [4:0]          key_len,
	input  logic [63:0]         key_low,
	input  logic [63:0]         key_high,
	input  logic [15:0]         conn_limit,
	input  logic                dry_run,
	input  logic [9:0]          reject_status,
	output logic [2:0]          status,
	output logic [9:0]          reject_code,
	output logic [15:0]         count_after
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int KEY_W = 8 * KEY_BYTES;

	typedef struct packed {
		logic             vld;
		logic [4:0]       len;
		logic [KEY_W-1:0] key;
		logic [15:0]      cnt;
	} entry_t;

	entry_t mem [TABLE_ENTRIES];
	entry_t rdata_s1;

	logic             op_q;
	logic [4:0]       len_q;
	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] key_in;

	logic [IDX_W-1:0] rd_idx_q;
	logic             issued_all_q;
	logic             issue;
	logic             rd_last;
	logic             rd_vld_s1;
	logic             rd_last_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [15:0]      hit_cnt_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             done_q;
	logic             match;
	logic             empty_slot;

	clt_pkg::status_t upd_status;
	logic [15:0]      upd_count;
	logic             upd_we;
	logic [IDX_W-1:0] upd_waddr;
	entry_t           upd_wdata;
	logic [15:0]      dec_cnt;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;

	clt_pkg::status_t res_status_q;
	logic [15:0]      res_count_q;

	assign key_in = KEY_W'({key_high, key_low} & clt_pkg::byte_mask(key_len));

	assign sts.skip       = (key_len == 5'd0) || (key_len > 5'(KEY_BYTES));
	assign sts.sweep_last = rd_last;
	assign sts.done       = done_q;

	assign rd_last = (rd_idx_q == IDX_W'(TABLE_ENTRIES - 1));
	assign issue   = cmd.scan && !issued_all_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			len_q <= key_len;
			key_q <= key_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q     <= '0;
			issued_all_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			rd_last_s1   <= 1'b0;
			rd_idx_s1    <= '0;
		end else begin
			if (cmd.load) begin
				rd_idx_q     <= '0;
				issued_all_q <= 1'b0;
			end else if (cmd.clear || issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
				if (issue && rd_last) begin
					issued_all_q <= 1'b1;
				end
			end
			rd_vld_s1  <= issue;
			rd_last_s1 <= rd_last;
			rd_idx_s1  <= rd_idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (issue) begin
			rdata_s1 <= mem[rd_idx_q];
		end
	end

	assign match = rd_vld_s1 && !done_q && rdata_s1.vld && (rdata_s1.len == len_q)
		&& (rdata_s1.key == key_q);
	assign empty_slot = rd_vld_s1 && !done_q && !rdata_s1.vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			hit_cnt_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
			done_q     <= 1'b0;
		end else if (cmd.load) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (match) begin
				hit_q     <= 1'b1;
				hit_idx_q <= rd_idx_s1;
				hit_cnt_q <= rdata_s1.cnt;
			end
			if (empty_slot && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= rd_idx_s1;
			end
			if (rd_vld_s1 && !done_q && (match || rd_last_s1)) begin
				done_q <= 1'b1;
			end
		end
	end

	assign dec_cnt = (hit_cnt_q == 16'd0) ? 16'd0 : hit_cnt_q - 16'd1;

	always_comb begin
		upd_status = clt_pkg::ST_PASSED;
		upd_count  = 16'd0;
		upd_we     = 1'b0;
		upd_waddr  = hit_idx_q;
		upd_wdata  = '{vld: 1'b1, len: len_q, key: key_q, cnt: 16'd1};
		if (op_q == clt_pkg::OP_ACQUIRE) begin
			if (hit_q) begin
				if (hit_cnt_q >= conn_limit) begin
					upd_status = dry_run ? clt_pkg::ST_REJECTED_DRY : clt_pkg::ST_REJECTED;
					upd_count  = hit_cnt_q;
				end else begin
					upd_we        = 1'b1;
					upd_wdata.cnt = hit_cnt_q + 16'd1;
					upd_count     = hit_cnt_q + 16'd1;
				end
			end else if (free_q) begin
				upd_we    = 1'b1;
				upd_waddr = free_idx_q;
				upd_count = 16'd1;
			end else begin
				upd_status = dry_run ? clt_pkg::ST_REJECTED_DRY : clt_pkg::ST_REJECTED;
			end
		end else begin
			if (hit_q) begin
				upd_status    = clt_pkg::ST_RELEASED;
				upd_we        = 1'b1;
				upd_wdata.vld = (dec_cnt != 16'd0);
				upd_wdata.cnt = dec_cnt;
				upd_count     = dec_cnt;
			end else begin
				upd_status = clt_pkg::ST_RELEASE_UNKNOWN;
			end
		end
	end

	assign mem_we    = cmd.clear || (cmd.update && upd_we);
	assign mem_waddr = cmd.clear ? rd_idx_q : upd_waddr;
	assign mem_wdata = cmd.clear ? entry_t'('0) : upd_wdata;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_status_q <= clt_pkg::ST_SKIPPED;
			res_count_q  <= 16'd0;
		end else if (cmd.update) begin
			res_status_q <= upd_status;
			res_count_q  <= upd_count;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status      <= res_status_q;
			reject_code <= (res_status_q == clt_pkg::ST_REJECTED) ? reject_status : 10'd0;
			count_after <= res_count_q;
		end
	end

endmodule

FILE: sv/clt_ctrl.sv
// ----------------------------------------------------------------------------
// Connection limit table controller
// Sequences the clearing pass, table scan, update and result hand-off.
// ----------------------------------------------------------------------------
module clt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output clt_pkg::cmd_t cmd,
	input  clt_pkg::sts_t sts
);

	clt_pkg::state_t state_q;
	clt_pkg::state_t state_nx;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= clt_pkg::S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			clt_pkg::S_CLEAR: begin
				if (sts.sweep_last) begin
					state_nx = clt_pkg::S_IDLE;
				end
			end
			clt_pkg::S_IDLE: begin
				if (in_valid) begin
					state_nx = sts.skip ? clt_pkg::S_RESP : clt_pkg::S_SCAN;
				end
			end
			clt_pkg::S_SCAN: begin
				if (sts.done) begin
					state_nx = clt_pkg::S_UPDATE;
				end
			end
			clt_pkg::S_UPDATE: begin
				state_nx = clt_pkg::S_RESP;
			end
			clt_pkg::S_RESP: begin
				if (out_free) begin
					state_nx = clt_pkg::S_IDLE;
				end
			end
			default: begin
				state_nx = clt_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			clt_pkg::S_CLEAR: begin
				cmd.clear = 1'b1;
			end
			clt_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			clt_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
			end
			clt_pkg::S_UPDATE: begin
				cmd.update = 1'b1;
			end
			clt_pkg::S_RESP: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: sv/connection_limit_table.sv
// ----------------------------------------------------------------------------
// Connection limit table
// Per-key open connection counter with a limit, dry-run and release.
// ----------------------------------------------------------------------------
// One item at a time. The key is looked up by a scan of the entry memory
// through its single read port, one entry per cycle, stopping at the first
// match. An empty or oversize key skips the scan and goes straight to the
// response state; any other key is scanned until a match or the last entry,
// then passes through the update state before the response state. A result
// can only be loaded once the one before it has been taken, so waiting on
// out_ready delays it. in_ready rises again in the cycle in which out_valid
// rises for the result. After reset a clearing pass writes every entry with
// in_ready low; register writes are taken meanwhile.
module connection_limit_table #(
	parameter int TABLE_ENTRIES = clt_pkg::TABLE_ENTRIES_DEF,
	parameter int KEY_BYTES     = clt_pkg::KEY_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [4:0]  key_len,
	input  logic [63:0] key_low,
	input  logic [63:0] key_high,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [9:0]  reject_code,
	output logic [15:0] count_after
);

	`include "connection_limit_table_defines.svh"

	logic [15:0] conn_limit_q;
	logic        dry_run_q;
	logic [9:0]  reject_status_q;
	logic        cfg_we;

	clt_pkg::cmd_t cmd;
	clt_pkg::sts_t sts;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conn_limit_q    <= clt_pkg::CONN_LIMIT_RST;
			dry_run_q       <= 1'b0;
			reject_status_q <= clt_pkg::REJECT_STATUS_RST;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				clt_pkg::REG_CONN_LIMIT:    conn_limit_q    <= pwdata[15:0];
				clt_pkg::REG_DRY_RUN:       dry_run_q       <= pwdata[0];
				clt_pkg::REG_REJECT_STATUS: reject_status_q <= pwdata[9:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			clt_pkg::REG_CONN_LIMIT:    prdata = {16'd0, conn_limit_q};
			clt_pkg::REG_DRY_RUN:       prdata = {31'd0, dry_run_q};
			clt_pkg::REG_REJECT_STATUS: prdata = {22'd0, reject_status_q};
			default:                    prdata = 32'd0;
		endcase
	end

	clt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	clt_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.KEY_BYTES     (KEY_BYTES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (operation),
		.key_len       (key_len),
		.key_low       (key_low),
		.key_high      (key_high),
		.conn_limit    (conn_limit_q),
		.dry_run       (dry_run_q),
		.reject_status (reject_status_q),
		.status        (status),
		.reject_code   (reject_code),
		.count_after   (count_after)
	);

	`CLT_ASSERT_IMP(a_code_only_on_reject, clk, arst_n,
		out_valid && (status != clt_pkg::ST_REJECTED), reject_code == 10'd0,
		"reject code set without enforced rejection")
	`CLT_ASSERT_IMP(a_zero_count, clk, arst_n,
		out_valid && ((status == clt_pkg::ST_SKIPPED) ||
		(status == clt_pkg::ST_RELEASE_UNKNOWN)), count_after == 16'd0,
		"nonzero count on skipped or unknown key")
	`CLT_ASSERT_IMP(a_pass_count, clk, arst_n,
		out_valid && (status == clt_pkg::ST_PASSED), count_after != 16'd0,
		"passed acquire with zero count")
	`CLT_ASSERT_NXT(a_one_item, clk, arst_n, in_valid && in_ready, !in_ready,
		"item accepted while another is in flight")

endmodule
